// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked on every rising edge outside reset.
`define FCL_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication between two conditions.
`define FCL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/fcl_pkg.sv -----
package fcl_pkg;

  localparam int CMD_W     = 2;
  localparam int CLUSTER_W = 28;
  localparam int CADDR_W   = 11;
  localparam int BYTE_W    = 8;
  localparam int SECTOR_W  = 21;
  localparam int NEXT_W    = 32;
  localparam int FAT_W     = 2;
  // Byte offset of a table entry: cluster * 4 fits in 30 bits.
  localparam int OFFSET_W  = 30;
  // The store is split into four byte lanes so one entry reads in one access.
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL   = 2'd0,
    CMD_BASE   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [FAT_W-1:0] {
    FAT12 = 2'd0,
    FAT16 = 2'd1,
    FAT32 = 2'd2
  } fat_e;

  localparam logic [11:0]       FAT12_EOC = 12'hFF8;
  localparam logic [NEXT_W-1:0] FAT12_EXT = 32'hFFFFF000;
  localparam logic [15:0]       FAT16_EOC = 16'hFFF8;
  localparam logic [NEXT_W-1:0] FAT16_EXT = 32'hFFFF0000;
  localparam logic [27:0]       FAT32_EOC = 28'hFFFFFF8;
  localparam logic [NEXT_W-1:0] FAT32_EXT = 32'hF0000000;
  localparam logic [NEXT_W-1:0] CHAIN_END = 32'hFFFFFFF8;

  // Store access issued by the window check stage.
  typedef struct packed {
    logic                lookup;
    logic                fill;
    logic                hit;
    fat_e                kind;
    logic                odd;
    logic [SECTOR_W-1:0] sector;
    logic [BYTE_W-1:0]   wdata;
  } mem_req_t;

  // Lookup context that travels alongside the registered read data.
  typedef struct packed {
    logic                lookup;
    logic                hit;
    fat_e                kind;
    logic                odd;
    logic [LANE_W-1:0]   lane;
    logic [SECTOR_W-1:0] sector;
  } rd_meta_t;

endpackage

// ----- design/fcl_req_if.sv -----
interface fcl_req_if;
  logic                           valid;
  logic                           ready;
  logic [fcl_pkg::CMD_W-1:0]      command;
  logic [fcl_pkg::CLUSTER_W-1:0]  cluster;
  logic [fcl_pkg::CADDR_W-1:0]    cache_address;
  logic [fcl_pkg::BYTE_W-1:0]     cache_byte;
  logic [fcl_pkg::SECTOR_W-1:0]   window_sector;

  modport source (
    output valid, command, cluster, cache_address, cache_byte, window_sector,
    input  ready
  );

  modport sink (
    input  valid, command, cluster, cache_address, cache_byte, window_sector,
    output ready
  );
endinterface

// ----- design/fcl_rsp_if.sv -----
interface fcl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fcl_pkg::NEXT_W-1:0]    next_cluster;
  logic                          end_of_chain;
  logic                          miss;
  logic [fcl_pkg::SECTOR_W-1:0]  miss_sector;

  modport source (
    output valid, next_cluster, end_of_chain, miss, miss_sector,
    input  ready
  );

  modport sink (
    input  valid, next_cluster, end_of_chain, miss, miss_sector,
    output ready
  );
endinterface

// ----- design/fcl_addr.sv -----
`include "assert_macros.svh"

module fcl_addr #(
  parameter int CACHE_SECTORS = 4,
  parameter int SECTOR_BYTES  = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                in_valid_i,
  input  logic [fcl_pkg::CMD_W-1:0]           command_i,
  input  logic [fcl_pkg::CLUSTER_W-1:0]       cluster_i,
  input  logic [fcl_pkg::CADDR_W-1:0]         cache_address_i,
  input  logic [fcl_pkg::BYTE_W-1:0]          cache_byte_i,
  input  logic [fcl_pkg::SECTOR_W-1:0]        window_sector_i,
  input  fcl_pkg::fat_e                       kind_i,
  output fcl_pkg::mem_req_t                   req_o,
  output logic [$clog2(CACHE_SECTORS*SECTOR_BYTES)-1:0] addr_o
);

  localparam int StoreBytes = CACHE_SECTORS * SECTOR_BYTES;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int SbLog2     = $clog2(SECTOR_BYTES);
  localparam int StartW     = fcl_pkg::SECTOR_W + SbLog2;
  localparam int CmpW       = ((fcl_pkg::OFFSET_W > StartW) ? fcl_pkg::OFFSET_W : StartW) + 1;
  localparam logic [CmpW-2:0] Lim2 = (CmpW-1)'(StoreBytes - 2);
  localparam logic [CmpW-2:0] Lim4 = (CmpW-1)'(StoreBytes - 4);

  // Input register.
  logic                              s1_valid_q;
  logic [fcl_pkg::CMD_W-1:0]         s1_cmd_q;
  logic                              s1_odd_q;
  logic [fcl_pkg::OFFSET_W-1:0]      s1_offset_q;
  logic [fcl_pkg::CADDR_W-1:0]       s1_caddr_q;
  logic [fcl_pkg::BYTE_W-1:0]        s1_byte_q;
  logic [fcl_pkg::SECTOR_W-1:0]      s1_wsec_q;

  // Window state.
  logic [fcl_pkg::SECTOR_W-1:0]      base_q;
  logic                              win_valid_q;

  logic [fcl_pkg::OFFSET_W-1:0]      triple;
  logic [fcl_pkg::OFFSET_W-1:0]      offset_d;
  logic [StartW-1:0]                 start;
  logic [CmpW-1:0]                   diff;
  logic [fcl_pkg::OFFSET_W-1:0]      sector_full;
  logic                              is_fill;
  logic                              is_base;
  logic                              is_lookup;
  logic                              fill_ok;
  logic                              hit;
  fcl_pkg::mem_req_t                 req_d;
  fcl_pkg::mem_req_t                 req_q;
  logic [AddrW-1:0]                  addr_d;
  logic [AddrW-1:0]                  addr_q;

  // FAT12 entries sit at one and a half bytes per cluster.
  assign triple = fcl_pkg::OFFSET_W'(cluster_i) + fcl_pkg::OFFSET_W'({cluster_i, 1'b0});

  always_comb begin
    case (kind_i)
      fcl_pkg::FAT12: offset_d = triple >> 1;
      fcl_pkg::FAT16: offset_d = fcl_pkg::OFFSET_W'({cluster_i, 1'b0});
      default:        offset_d = fcl_pkg::OFFSET_W'({cluster_i, 2'b00});
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      s1_cmd_q    <= command_i;
      s1_odd_q    <= cluster_i[0];
      s1_offset_q <= offset_d;
      s1_caddr_q  <= cache_address_i;
      s1_byte_q   <= cache_byte_i;
      s1_wsec_q   <= window_sector_i;
    end
  end

  always_comb begin
    is_fill   = 1'b0;
    is_base   = 1'b0;
    is_lookup = 1'b0;
    case (s1_cmd_q)
      fcl_pkg::CMD_FILL:   is_fill   = s1_valid_q;
      fcl_pkg::CMD_BASE:   is_base   = s1_valid_q;
      fcl_pkg::CMD_LOOKUP: is_lookup = s1_valid_q;
      default:             ;
    endcase
  end

  // The base changes in this stage so lookups see bases in command order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      win_valid_q <= 1'b0;
    end else if (adv_i && is_base) begin
      base_q      <= s1_wsec_q;
      win_valid_q <= 1'b1;
    end
  end

  // The sign bit of the difference flags an entry below the window start.
  assign start       = StartW'(base_q) << SbLog2;
  assign diff        = CmpW'(s1_offset_q) - CmpW'(start);
  assign sector_full = s1_offset_q >> SbLog2;
  assign fill_ok     = 32'(s1_caddr_q) < 32'(StoreBytes);

  always_comb begin
    hit = win_valid_q && !diff[CmpW-1];
    if (kind_i inside {fcl_pkg::FAT12, fcl_pkg::FAT16}) begin
      hit = hit && (diff[CmpW-2:0] <= Lim2);
    end else begin
      hit = hit && (diff[CmpW-2:0] <= Lim4);
    end
  end

  always_comb begin
    req_d.lookup = is_lookup;
    req_d.fill   = is_fill && fill_ok;
    req_d.hit    = hit;
    req_d.kind   = kind_i;
    req_d.odd    = s1_odd_q;
    req_d.sector = sector_full[fcl_pkg::SECTOR_W-1:0];
    req_d.wdata  = s1_byte_q;
    addr_d       = is_lookup ? AddrW'(diff) : AddrW'(s1_caddr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else if (adv_i) begin
      req_q <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      addr_q <= addr_d;
    end
  end

  assign req_o  = req_q;
  assign addr_o = addr_q;

  `FCL_ASSERT(a_base_opens_window, clk_i, rst_ni, adv_i && is_base |=> win_valid_q, "base command did not open the window")
  `FCL_ASSERT_IMPL(a_hit_needs_window, clk_i, rst_ni, req_q.lookup && req_q.hit, win_valid_q, "hit without a valid window")

endmodule

// ----- design/fcl_store.sv -----
`include "assert_macros.svh"

module fcl_store #(
  parameter int CACHE_SECTORS = 4,
  parameter int SECTOR_BYTES  = 512
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              adv_i,
  input  fcl_pkg::mem_req_t                                 req_i,
  input  logic [$clog2(CACHE_SECTORS*SECTOR_BYTES)-1:0]     addr_i,
  output fcl_pkg::rd_meta_t                                 meta_o,
  output logic [fcl_pkg::LANES-1:0][fcl_pkg::BYTE_W-1:0]    rdata_o
);

  localparam int StoreBytes = CACHE_SECTORS * SECTOR_BYTES;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int BankDepth  = (StoreBytes + fcl_pkg::LANES - 1) / fcl_pkg::LANES;
  localparam int RowW       = $clog2(BankDepth);
  localparam int LaneW      = fcl_pkg::LANE_W;

  fcl_pkg::rd_meta_t meta_q;
  logic [RowW-1:0]   wrow;

  assign wrow = RowW'(addr_i >> LaneW);

  // Byte k of an entry lives in lane (addr + k) mod 4; each lane reads the
  // row that holds its byte, which is one row further for lanes below addr.
  for (genvar b = 0; b < fcl_pkg::LANES; b++) begin : g_lane
    logic [fcl_pkg::BYTE_W-1:0] mem [BankDepth];
    logic [fcl_pkg::BYTE_W-1:0] rd_q;
    logic [LaneW-1:0]           k;
    logic [AddrW:0]             row_sum;
    logic [RowW-1:0]            rrow;
    logic                       we;

    assign k       = LaneW'(b) - addr_i[LaneW-1:0];
    assign row_sum = (AddrW+1)'(addr_i) + (AddrW+1)'(k);
    assign rrow    = RowW'(row_sum >> LaneW);
    assign we      = adv_i && req_i.fill && (addr_i[LaneW-1:0] == LaneW'(b));

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[wrow] <= req_i.wdata;
      end
      if (adv_i && req_i.lookup && req_i.hit) begin
        rd_q <= mem[rrow];
      end
    end

    assign rdata_o[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (adv_i) begin
      meta_q.lookup <= req_i.lookup;
      meta_q.hit    <= req_i.hit;
      meta_q.kind   <= req_i.kind;
      meta_q.odd    <= req_i.odd;
      meta_q.lane   <= addr_i[LaneW-1:0];
      meta_q.sector <= req_i.sector;
    end
  end

  assign meta_o = meta_q;

  `FCL_ASSERT(a_lookup_reaches_read, clk_i, rst_ni, adv_i && req_i.lookup |=> meta_q.lookup, "lookup lost at the store read stage")

endmodule

// ----- design/fcl_decode.sv -----
`include "assert_macros.svh"

module fcl_decode (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  fcl_pkg::rd_meta_t                              meta_i,
  input  logic [fcl_pkg::LANES-1:0][fcl_pkg::BYTE_W-1:0] rdata_i,
  output logic                                           adv_o,
  fcl_rsp_if.source                                      rsp_o
);

  logic [fcl_pkg::LANES-1:0][fcl_pkg::BYTE_W-1:0] bytes;
  logic [15:0]                   v16;
  logic [11:0]                   v12;
  logic [27:0]                   v28;
  logic [fcl_pkg::NEXT_W-1:0]    value;
  logic [fcl_pkg::NEXT_W-1:0]    next_d;
  logic                          eoc_d;
  logic [fcl_pkg::SECTOR_W-1:0]  sector_d;

  logic                          valid_q;
  logic [fcl_pkg::NEXT_W-1:0]    next_q;
  logic                          eoc_q;
  logic                          miss_q;
  logic [fcl_pkg::SECTOR_W-1:0]  sector_q;
  logic                          adv;

  // Rotate the lanes so byte 0 is the entry's first byte.
  always_comb begin
    for (int k = 0; k < fcl_pkg::LANES; k++) begin
      bytes[k] = rdata_i[fcl_pkg::LANE_W'(meta_i.lane + fcl_pkg::LANE_W'(k))];
    end
  end

  assign v16 = {bytes[1], bytes[0]};
  assign v12 = meta_i.odd ? v16[15:4] : v16[11:0];
  assign v28 = {bytes[3][3:0], bytes[2], bytes[1], bytes[0]};

  always_comb begin
    case (meta_i.kind)
      fcl_pkg::FAT12: begin
        value = fcl_pkg::NEXT_W'(v12);
        if (v12 >= fcl_pkg::FAT12_EOC) begin
          value = value | fcl_pkg::FAT12_EXT;
        end
      end
      fcl_pkg::FAT16: begin
        value = fcl_pkg::NEXT_W'(v16);
        if (v16 >= fcl_pkg::FAT16_EOC) begin
          value = value | fcl_pkg::FAT16_EXT;
        end
      end
      default: begin
        value = fcl_pkg::NEXT_W'(v28);
        if (v28 >= fcl_pkg::FAT32_EOC) begin
          value = value | fcl_pkg::FAT32_EXT;
        end
      end
    endcase
  end

  assign next_d   = meta_i.hit ? value : '0;
  assign eoc_d    = meta_i.hit && (value >= fcl_pkg::CHAIN_END);
  assign sector_d = meta_i.hit ? '0 : meta_i.sector;

  // The whole pipeline moves only when this register can take a beat.
  assign adv = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= meta_i.lookup;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && meta_i.lookup) begin
      next_q   <= next_d;
      eoc_q    <= eoc_d;
      miss_q   <= !meta_i.hit;
      sector_q <= sector_d;
    end
  end

  assign adv_o              = adv;
  assign rsp_o.valid        = valid_q;
  assign rsp_o.next_cluster = next_q;
  assign rsp_o.end_of_chain = eoc_q;
  assign rsp_o.miss         = miss_q;
  assign rsp_o.miss_sector  = sector_q;

  `FCL_ASSERT_IMPL(a_miss_is_empty, clk_i, rst_ni, valid_q && miss_q, (next_q == '0) && !eoc_q, "miss result carries a cluster")
  `FCL_ASSERT_IMPL(a_hit_no_sector, clk_i, rst_ni, valid_q && !miss_q, sector_q == '0, "hit result carries a sector")

endmodule

// ----- design/fat_cluster_chain_lookup.sv -----
// Channel  Direction  Handshake       Beat contents
// req_i    in         valid / ready   command, cluster, cache_address, cache_byte,
//                                     window_sector
// rsp_o    out        valid / ready   next_cluster, end_of_chain, miss, miss_sector
// cfg      in         cfg_we_i        fat_type on cfg_data_i
//
// One beat is accepted per cycle unless the stages stall; a lookup passes the input
// register, window check, one read of the four-lane byte store, and decode.
// Fills write one lane of the store; base commands and fills give no result.
// Reset clears the window, its base, the format register and the pipeline;
// store contents are undefined until filled.
// When the output register holds a beat that is not taken, all stages stall.
module fat_cluster_chain_lookup #(
  parameter int CACHE_SECTORS = 4,
  parameter int SECTOR_BYTES  = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fcl_pkg::FAT_W-1:0]   cfg_data_i,
  fcl_req_if.sink                     req_i,
  fcl_rsp_if.source                   rsp_o
);

  localparam int AddrW = $clog2(CACHE_SECTORS * SECTOR_BYTES);

  logic [fcl_pkg::FAT_W-1:0]                       fat_q;
  fcl_pkg::fat_e                                   kind;
  logic                                            adv;
  fcl_pkg::mem_req_t                               mem_req;
  logic [AddrW-1:0]                                mem_addr;
  fcl_pkg::rd_meta_t                               rd_meta;
  logic [fcl_pkg::LANES-1:0][fcl_pkg::BYTE_W-1:0]  rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_q <= fcl_pkg::FAT12;
    end else if (cfg_we_i) begin
      fat_q <= cfg_data_i;
    end
  end

  // The unused format code reads as FAT32.
  always_comb begin
    case (fat_q)
      fcl_pkg::FAT12: kind = fcl_pkg::FAT12;
      fcl_pkg::FAT16: kind = fcl_pkg::FAT16;
      default:        kind = fcl_pkg::FAT32;
    endcase
  end

  assign req_i.ready = adv;

  fcl_addr #(
    .CACHE_SECTORS (CACHE_SECTORS),
    .SECTOR_BYTES  (SECTOR_BYTES)
  ) u_addr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_valid_i      (req_i.valid),
    .command_i       (req_i.command),
    .cluster_i       (req_i.cluster),
    .cache_address_i (req_i.cache_address),
    .cache_byte_i    (req_i.cache_byte),
    .window_sector_i (req_i.window_sector),
    .kind_i          (kind),
    .req_o           (mem_req),
    .addr_o          (mem_addr)
  );

  fcl_store #(
    .CACHE_SECTORS (CACHE_SECTORS),
    .SECTOR_BYTES  (SECTOR_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .meta_o  (rd_meta),
    .rdata_o (rd_data)
  );

  fcl_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .meta_i  (rd_meta),
    .rdata_i (rd_data),
    .adv_o   (adv),
    .rsp_o   (rsp_o)
  );

endmodule

// ----- tb/fat_cluster_chain_lookup_tb.sv -----
module fat_cluster_chain_lookup_tb;

  localparam int CACHE_SECTORS = 4;
  localparam int SECTOR_BYTES  = 512;
  localparam int STORE_BYTES   = CACHE_SECTORS * SECTOR_BYTES;

  localparam logic [fcl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [fcl_pkg::FAT_W-1:0] FAT_SPARE  = 2'd3;

  localparam logic [31:0] LOW12      = 32'h0000_0FFF;
  localparam logic [31:0] EOC12      = 32'h0000_0FF8;
  localparam logic [31:0] EXT12      = 32'hFFFF_F000;
  localparam logic [31:0] EOC16      = 32'h0000_FFF8;
  localparam logic [31:0] EXT16      = 32'hFFFF_0000;
  localparam logic [31:0] MASK28     = 32'h0FFF_FFFF;
  localparam logic [31:0] EOC28      = 32'h0FFF_FFF8;
  localparam logic [31:0] EXT28      = 32'hF000_0000;
  localparam logic [31:0] CHAIN_LAST = 32'hFFFF_FFF8;
  localparam logic [fcl_pkg::CLUSTER_W-1:0] CLUSTER_MAX = 28'hFFF_FFFF;

  localparam int SEG_ITEMS    = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [fcl_pkg::CMD_W-1:0]     command;
    logic [fcl_pkg::CLUSTER_W-1:0] cluster;
    logic [fcl_pkg::CADDR_W-1:0]   cache_address;
    logic [fcl_pkg::BYTE_W-1:0]    cache_byte;
    logic [fcl_pkg::SECTOR_W-1:0]  window_sector;
  } req_beat_t;

  typedef struct packed {
    logic [fcl_pkg::NEXT_W-1:0]   next_cluster;
    logic                         end_of_chain;
    logic                         miss;
    logic [fcl_pkg::SECTOR_W-1:0] miss_sector;
  } lookup_answer_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [fcl_pkg::FAT_W-1:0]    cfg_data_i;

  fcl_req_if req_if ();
  fcl_rsp_if rsp_if ();

  fat_cluster_chain_lookup #(
    .CACHE_SECTORS(CACHE_SECTORS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Beats waiting to be driven, and what each accepted lookup should return.
  req_beat_t      beats_to_send [$];
  lookup_answer_t predicted_answers [$];
  int             beats_left = 0;
  bit             beat_taken = 1'b0;
  int unsigned    send_idle_pct = 0;
  int unsigned    sink_stall_pct = 0;

  // Predictor state, advanced as beats are accepted.
  logic [7:0]                   window_bytes [STORE_BYTES];
  logic [fcl_pkg::SECTOR_W-1:0] win_base = '0;
  bit                           win_valid = 1'b0;
  logic [fcl_pkg::FAT_W-1:0]    fat_cfg = fcl_pkg::FAT12;

  // Generator view of the same state, advanced as beats are queued.
  bit                           gen_written [STORE_BYTES];
  logic [fcl_pkg::SECTOR_W-1:0] gen_base = '0;
  bit                           gen_valid = 1'b0;
  logic [fcl_pkg::FAT_W-1:0]    gen_fat = fcl_pkg::FAT12;
  int                           seg_count = 0;

  int fail_count = 0;
  int beats_accepted = 0;
  int lookups_seen = 0;
  int hits_seen = 0;
  int eoc_seen = 0;
  int unsigned cycle_count = 0;

  int          send_idle_by_phase [4] = '{0, 63, 0, 32};
  int          sink_stall_by_phase [4] = '{0, 0, 63, 32};
  logic [fcl_pkg::FAT_W-1:0] fat_plan [8] = '{fcl_pkg::FAT16, fcl_pkg::FAT32, FAT_SPARE,
                                              fcl_pkg::FAT12, fcl_pkg::FAT32, fcl_pkg::FAT16,
                                              fcl_pkg::FAT12, FAT_SPARE};

  req_beat_t      drive_beat;
  lookup_answer_t want_answer;
  lookup_answer_t new_answer;

  function automatic fcl_pkg::fat_e entry_kind(logic [fcl_pkg::FAT_W-1:0] cfg);
    if (cfg == fcl_pkg::FAT12) return fcl_pkg::FAT12;
    if (cfg == fcl_pkg::FAT16) return fcl_pkg::FAT16;
    return fcl_pkg::FAT32;
  endfunction

  function automatic longint unsigned entry_offset(fcl_pkg::fat_e kind,
                                                   logic [fcl_pkg::CLUSTER_W-1:0] cl);
    case (kind)
      fcl_pkg::FAT12: return (longint'(cl) * 3) >> 1;
      fcl_pkg::FAT16: return longint'(cl) * 2;
      default:        return longint'(cl) * 4;
    endcase
  endfunction

  function automatic int entry_bytes(fcl_pkg::fat_e kind);
    return (kind == fcl_pkg::FAT32) ? 4 : 2;
  endfunction

  function automatic bit in_window(bit valid_w, logic [fcl_pkg::SECTOR_W-1:0] base_w,
                                   fcl_pkg::fat_e kind, logic [fcl_pkg::CLUSTER_W-1:0] cl,
                                   output longint unsigned loc_pos);
    longint unsigned off;
    longint unsigned start;
    off = entry_offset(kind, cl);
    start = longint'(base_w) * SECTOR_BYTES;
    loc_pos = off - start;
    return valid_w && off >= start && (off - start) + entry_bytes(kind) <= STORE_BYTES;
  endfunction

  function automatic lookup_answer_t predict_lookup(logic [fcl_pkg::CLUSTER_W-1:0] cl);
    fcl_pkg::fat_e   kind;
    longint unsigned loc_pos;
    logic [15:0]     raw;
    logic [31:0]     v;
    lookup_answer_t  r;
    kind = entry_kind(fat_cfg);
    r = '0;
    if (!in_window(win_valid, win_base, kind, cl, loc_pos)) begin
      r.miss = 1'b1;
      r.miss_sector = fcl_pkg::SECTOR_W'(entry_offset(kind, cl) / SECTOR_BYTES);
      return r;
    end
    raw = {window_bytes[loc_pos + 1], window_bytes[loc_pos]};
    case (kind)
      fcl_pkg::FAT12: begin
        v = cl[0] ? 32'(raw >> 4) : (32'(raw) & LOW12);
        if (v >= EOC12) v = v | EXT12;
      end
      fcl_pkg::FAT16: begin
        v = 32'(raw);
        if (v >= EOC16) v = v | EXT16;
      end
      default: begin
        v = {window_bytes[loc_pos + 3], window_bytes[loc_pos + 2], raw} & MASK28;
        if (v >= EOC28) v = v | EXT28;
      end
    endcase
    r.next_cluster = v;
    r.end_of_chain = (v >= CHAIN_LAST);
    return r;
  endfunction

  // A lookup that would read store bytes never filled is never issued.
  function automatic bit lookup_allowed(logic [fcl_pkg::CLUSTER_W-1:0] cl);
    fcl_pkg::fat_e   kind;
    longint unsigned loc_pos;
    kind = entry_kind(gen_fat);
    if (!in_window(gen_valid, gen_base, kind, cl, loc_pos)) return 1'b1;
    for (int i = 0; i < entry_bytes(kind); i++) begin
      if (!gen_written[loc_pos + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit cluster_for_offset(fcl_pkg::fat_e kind, longint unsigned abs_off,
                                            output logic [fcl_pkg::CLUSTER_W-1:0] cl);
    longint unsigned c;
    case (kind)
      fcl_pkg::FAT12: c = (abs_off * 2) / 3;
      fcl_pkg::FAT16: c = abs_off / 2;
      default:        c = abs_off / 4;
    endcase
    cl = fcl_pkg::CLUSTER_W'(c);
    return c <= CLUSTER_MAX;
  endfunction

  function automatic logic [fcl_pkg::SECTOR_W-1:0] pick_base(fcl_pkg::fat_e kind);
    int unsigned top;
    int unsigned pick;
    top = int'(entry_offset(kind, CLUSTER_MAX) / SECTOR_BYTES);
    pick = $urandom_range(0, 9);
    if (pick < 3) return fcl_pkg::SECTOR_W'($urandom_range(0, 7));
    if (pick == 3) return fcl_pkg::SECTOR_W'($urandom_range(top - 3, top));
    return fcl_pkg::SECTOR_W'($urandom_range(0, top - 4));
  endfunction

  function automatic logic [7:0] fill_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 8'hFF;
    if (pick == 3) return $urandom_range(0, 1) ? 8'hF8 : 8'hF7;
    if (pick == 4) return 8'h0F;
    return 8'($urandom);
  endfunction

  function automatic req_beat_t rand_beat();
    req_beat_t b;
    b.command = fcl_pkg::CMD_W'($urandom_range(0, 3));
    b.cluster = fcl_pkg::CLUSTER_W'($urandom);
    b.cache_address = fcl_pkg::CADDR_W'($urandom);
    b.cache_byte = fcl_pkg::BYTE_W'($urandom);
    b.window_sector = fcl_pkg::SECTOR_W'($urandom);
    return b;
  endfunction

  task automatic push_beat(req_beat_t b);
    beats_to_send.push_back(b);
    beats_left++;
    case (b.command)
      fcl_pkg::CMD_FILL: gen_written[b.cache_address] = 1'b1;
      fcl_pkg::CMD_BASE: begin
        gen_base = b.window_sector;
        gen_valid = 1'b1;
      end
      default: ;
    endcase
    if (b.command != CMD_UNUSED) seg_count++;
  endtask

  task automatic push_fill(logic [fcl_pkg::CADDR_W-1:0] addr, logic [7:0] value);
    req_beat_t b;
    b = rand_beat();
    b.command = fcl_pkg::CMD_FILL;
    b.cache_address = addr;
    b.cache_byte = value;
    push_beat(b);
  endtask

  task automatic push_base(logic [fcl_pkg::SECTOR_W-1:0] sector);
    req_beat_t b;
    b = rand_beat();
    b.command = fcl_pkg::CMD_BASE;
    b.window_sector = sector;
    push_beat(b);
  endtask

  task automatic push_lookup(logic [fcl_pkg::CLUSTER_W-1:0] cl);
    req_beat_t b;
    b = rand_beat();
    b.command = fcl_pkg::CMD_LOOKUP;
    b.cluster = cl;
    if (lookup_allowed(cl)) push_beat(b);
  endtask

  task automatic push_spare();
    req_beat_t b;
    b = rand_beat();
    b.command = CMD_UNUSED;
    push_beat(b);
  endtask

  // Load a window the way a host would: set the base, fill a stretch of it, then walk
  // entries inside that stretch, around the window edges and at random offsets.
  task automatic window_burst();
    fcl_pkg::fat_e                 kind;
    int unsigned                   span;
    int unsigned                   first;
    int unsigned                   n_look;
    int unsigned                   pick;
    longint unsigned               win_start;
    longint unsigned               abs_off;
    logic [fcl_pkg::CLUSTER_W-1:0] cl;
    kind = entry_kind(gen_fat);
    push_base(pick_base(kind));
    span = $urandom_range(6, 40);
    first = $urandom_range(0, STORE_BYTES - span);
    for (int i = 0; i < span; i++) begin
      push_fill(fcl_pkg::CADDR_W'(first + i), fill_byte());
      if ($urandom_range(0, 19) == 0) push_spare();
    end
    win_start = longint'(gen_base) * SECTOR_BYTES;
    n_look = $urandom_range(4, 16);
    for (int j = 0; j < n_look; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        abs_off = win_start + first + $urandom_range(0, span - 1);
      end else if (pick < 85 || win_start < 8) begin
        abs_off = win_start + STORE_BYTES - 6 + $urandom_range(0, 10);
      end else if (pick < 92) begin
        abs_off = win_start - $urandom_range(1, 8);
      end else begin
        abs_off = longint'($urandom_range(0, 32'h3FFF_FFFF));
      end
      if (cluster_for_offset(kind, abs_off, cl)) push_lookup(cl);
    end
  endtask

  task automatic noise_burst();
    int unsigned n;
    req_beat_t   b;
    n = $urandom_range(3, 10);
    for (int i = 0; i < n; i++) begin
      b = rand_beat();
      if (b.command != fcl_pkg::CMD_LOOKUP || lookup_allowed(b.cluster)) push_beat(b);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (beats_left != 0 || predicted_answers.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_fat_type(logic [fcl_pkg::FAT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gen_fat = value;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin
    if (!req_if.valid || beat_taken) begin
      if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_beat = beats_to_send.pop_front();
        req_if.valid <= 1'b1;
        req_if.command <= drive_beat.command;
        req_if.cluster <= drive_beat.cluster;
        req_if.cache_address <= drive_beat.cache_address;
        req_if.cache_byte <= drive_beat.cache_byte;
        req_if.window_sector <= drive_beat.window_sector;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    beat_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (cfg_we_i) fat_cfg = cfg_data_i;
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_answers.size() == 0) begin
          $error("result beat with no lookup outstanding: next_cluster %h, miss %b",
                 rsp_if.next_cluster, rsp_if.miss);
          fail_count++;
        end else begin
          want_answer = predicted_answers.pop_front();
          check_field("next_cluster", want_answer.next_cluster, rsp_if.next_cluster);
          check_field("end_of_chain", 32'(want_answer.end_of_chain), 32'(rsp_if.end_of_chain));
          check_field("miss", 32'(want_answer.miss), 32'(rsp_if.miss));
          check_field("miss_sector", 32'(want_answer.miss_sector), 32'(rsp_if.miss_sector));
        end
      end
      if (req_if.valid && req_if.ready) begin
        beats_left--;
        beats_accepted++;
        case (req_if.command)
          fcl_pkg::CMD_FILL: begin
            if (req_if.cache_address < STORE_BYTES)
              window_bytes[req_if.cache_address] = req_if.cache_byte;
          end
          fcl_pkg::CMD_BASE: begin
            win_base = req_if.window_sector;
            win_valid = 1'b1;
          end
          fcl_pkg::CMD_LOOKUP: begin
            new_answer = predict_lookup(req_if.cluster);
            lookups_seen++;
            if (!new_answer.miss) hits_seen++;
            if (new_answer.end_of_chain) eoc_seen++;
            predicted_answers.push_back(new_answer);
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[fat_cluster_chain_lookup] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.command = '0;
    req_if.cluster = '0;
    req_if.cache_address = '0;
    req_if.cache_byte = '0;
    req_if.window_sector = '0;
    rsp_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No window yet, so every lookup misses.
    push_lookup('0);
    push_lookup(CLUSTER_MAX);
    push_spare();
    push_base('0);
    push_fill(11'd0, 8'hF8);
    push_fill(11'd1, 8'hFF);
    push_fill(11'd2, 8'hFF);
    push_fill(11'd3, 8'hFF);
    push_fill(11'd4, 8'h12);
    push_fill(11'd5, 8'h00);
    push_fill(11'd2046, 8'hAB);
    push_fill(11'd2047, 8'hCD);
    push_lookup(28'd0);
    push_lookup(28'd1);
    push_lookup(28'd2);
    push_lookup(28'd3);
    push_lookup(28'd1364);
    // This FAT12 entry starts on the last byte of the window and must miss.
    push_lookup(28'd1365);
    wait_idle();
    write_fat_type(fcl_pkg::FAT16);
    push_lookup(28'd0);
    push_lookup(28'd1);
    push_lookup(28'd1024);
    wait_idle();
    write_fat_type(fcl_pkg::FAT32);
    push_lookup(28'd0);
    push_base(21'h1F_FFFF);
    push_lookup(28'd0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 2; s++) begin
        wait_idle();
        send_idle_pct = send_idle_by_phase[ph];
        sink_stall_pct = sink_stall_by_phase[ph];
        write_fat_type(fat_plan[ph * 2 + s]);
        seg_count = 0;
        while (seg_count < SEG_ITEMS) begin
          if ($urandom_range(0, 99) < 85) window_burst();
          else noise_burst();
        end
      end
    end
    wait_idle();

    $display("Run covered %0d beats and %0d lookups (%0d hits, %0d misses, %0d end of chain)",
             beats_accepted, lookups_seen, hits_seen, lookups_seen - hits_seen, eoc_seen);
    $display("under all four fat_type codes and four sender/receiver idling mixes.");
    if (fail_count == 0) begin
      $display("[fat_cluster_chain_lookup] OK");
    end else begin
      $display("[fat_cluster_chain_lookup] ERROR");
    end
    $finish;
  end

endmodule
